>>> rtl/tmpal_pkg.sv
// Shared types, codes and reset values for the temperature alarm monitor.
`default_nettype none

package tmpal_pkg;

  localparam int unsigned TEMP_W  = 9;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned IDX_W   = 2;

  localparam logic signed [TEMP_W-1:0] CRIT_HIGH_RST = 9'sd150;
  localparam logic signed [TEMP_W-1:0] WARN_HIGH_RST = 9'sd140;
  localparam logic signed [TEMP_W-1:0] WARN_LOW_RST  = 9'sd0;
  localparam logic signed [TEMP_W-1:0] CRIT_LOW_RST  = -9'sd40;

  // Code of the normal-1 state, also the state after reset.
  localparam logic [STATE_W-1:0] STATE_NORM1_CODE = 4'd0;

  typedef enum logic [IDX_W-1:0] {
    REG_CRIT_HIGH = 2'd0,
    REG_WARN_HIGH = 2'd1,
    REG_WARN_LOW  = 2'd2,
    REG_CRIT_LOW  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_LOWARN  = 3'd1,
    EV_HIWARN  = 3'd2,
    EV_HIALARM = 3'd3,
    EV_LOALARM = 3'd4
  } ev_t;

  typedef enum logic [1:0] {
    LED_NONE   = 2'd0,
    LED_NORMAL = 2'd1,
    LED_WARN   = 2'd2,
    LED_CRIT   = 2'd3
  } led_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] crit_high;
    logic signed [TEMP_W-1:0] warn_high;
    logic signed [TEMP_W-1:0] warn_low;
    logic signed [TEMP_W-1:0] crit_low;
  } thr_t;

  typedef struct packed {
    logic                     op;
    logic signed [TEMP_W-1:0] temperature;
  } sample_t;

  typedef struct packed {
    ev_t                alarm_event;
    led_t               led_command;
    logic [STATE_W-1:0] monitor_state;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/tmpal_ifs.sv
// Valid/ready channel interfaces for samples, results and register writes.
`default_nettype none

interface tmpal_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    op;
  logic signed [tmpal_pkg::TEMP_W-1:0]     temperature;

  modport source (output valid, output op, output temperature, input ready);
  modport sink   (input valid, input op, input temperature, output ready);
endinterface

interface tmpal_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [2:0]                              alarm_event;
  logic [1:0]                              led_command;
  logic [tmpal_pkg::STATE_W-1:0]           monitor_state;

  modport source (output valid, output alarm_event, output led_command,
                  output monitor_state, input ready);
  modport sink   (input valid, input alarm_event, input led_command,
                  input monitor_state, output ready);
endinterface

interface tmpal_cfg_if;
  logic                                    valid;
  logic                                    ready;
  logic [tmpal_pkg::IDX_W-1:0]             reg_idx;
  logic [tmpal_pkg::TEMP_W-1:0]            wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink   (input valid, input reg_idx, input wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/temperature_alarm_fsm.sv
// Top level of the temperature alarm monitor.
`default_nettype none

// A sample beat is captured by the input register on acceptance and waits there
// while the compare and transition logic works on it; the result register
// captures the outcome when the beat is taken. One beat is accepted
// per cycle while the sink keeps up; a result held by the sink keeps the next
// beat in the input register, and the input stalls once both are full. The
// state register is updated as each beat enters the result register, so the
// next beat is evaluated against it. Threshold writes take effect on the cycle
// after the write beat; the configuration channel is always ready.
module temperature_alarm_fsm (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tmpal_in_if.sink   in_chan,
  tmpal_out_if.source out_chan,
  tmpal_cfg_if.sink  cfg_chan
);

  tmpal_pkg::thr_t    thr;
  tmpal_pkg::sample_t smp;
  tmpal_pkg::result_t res;
  logic               smp_valid;
  logic               take;

  tmpal_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .thr      (thr)
  );

  tmpal_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .take      (take),
    .smp_valid (smp_valid),
    .smp       (smp)
  );

  tmpal_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (smp_valid),
    .smp       (smp),
    .thr       (thr),
    .take      (take),
    .res_ready (out_chan.ready),
    .res_valid (out_chan.valid),
    .res       (res)
  );

  assign out_chan.alarm_event   = res.alarm_event;
  assign out_chan.led_command   = res.led_command;
  assign out_chan.monitor_state = res.monitor_state;

  // A reset operation lands in normal-1 with no event and no LED change.
  a_reset_op: assert property (@(posedge clk) disable iff (!rst_n)
    (take && smp.op) |=>
      (out_chan.valid && out_chan.monitor_state == tmpal_pkg::STATE_NORM1_CODE &&
       out_chan.alarm_event == tmpal_pkg::EV_NONE &&
       out_chan.led_command == tmpal_pkg::LED_NONE))
    else $error("reset operation gave a wrong result");

  // Every event comes with a transition, hence an LED command.
  a_event_led: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.alarm_event != tmpal_pkg::EV_NONE) |->
      (out_chan.led_command != tmpal_pkg::LED_NONE))
    else $error("alarm event without LED command");

  // Input stalls only when both stages are full and the sink holds off.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (smp_valid && out_chan.valid && !out_chan.ready))
    else $error("input stalled without backpressure");

endmodule

`default_nettype wire

>>> rtl/tmpal_cfg_regs.sv
// Threshold registers, written by index through the configuration channel.
`default_nettype none

module tmpal_cfg_regs (
  input  wire logic             clk,
  input  wire logic             rst_n,
  tmpal_cfg_if.sink             cfg_chan,
  output tmpal_pkg::thr_t       thr
);

  tmpal_pkg::thr_t thr_r;

  assign cfg_chan.ready = 1'b1;
  assign thr            = thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.crit_high <= tmpal_pkg::CRIT_HIGH_RST;
      thr_r.warn_high <= tmpal_pkg::WARN_HIGH_RST;
      thr_r.warn_low  <= tmpal_pkg::WARN_LOW_RST;
      thr_r.crit_low  <= tmpal_pkg::CRIT_LOW_RST;
    end else if (cfg_chan.valid) begin
      case (tmpal_pkg::reg_idx_t'(cfg_chan.reg_idx))
        tmpal_pkg::REG_CRIT_HIGH: thr_r.crit_high <= cfg_chan.wdata;
        tmpal_pkg::REG_WARN_HIGH: thr_r.warn_high <= cfg_chan.wdata;
        tmpal_pkg::REG_WARN_LOW:  thr_r.warn_low  <= cfg_chan.wdata;
        tmpal_pkg::REG_CRIT_LOW:  thr_r.crit_low  <= cfg_chan.wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/tmpal_in_stage.sv
// Input register: captures one sample beat and holds it until the monitor takes it.
`default_nettype none

module tmpal_in_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  tmpal_in_if.sink              in_chan,
  input  wire logic             take,
  output logic                  smp_valid,
  output tmpal_pkg::sample_t    smp
);

  logic               valid_r;
  tmpal_pkg::sample_t smp_r;
  logic               accept;

  // Refill in the same cycle that the held beat moves on.
  assign in_chan.ready = !valid_r || take;
  assign accept        = in_chan.valid && in_chan.ready;
  assign smp_valid     = valid_r;
  assign smp           = smp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (accept) begin
        valid_r           <= 1'b1;
        smp_r.op          <= in_chan.op;
        smp_r.temperature <= in_chan.temperature;
      end else if (take) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/tmpal_fsm.sv
// Nine-state monitor: transition logic, state register and result register.
`default_nettype none

module tmpal_fsm (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             smp_valid,
  input  wire tmpal_pkg::sample_t smp,
  input  wire tmpal_pkg::thr_t  thr,
  output logic                  take,
  input  wire logic             res_ready,
  output logic                  res_valid,
  output tmpal_pkg::result_t    res
);

  typedef enum logic [tmpal_pkg::STATE_W-1:0] {
    ST_NORM1   = tmpal_pkg::STATE_NORM1_CODE,
    ST_NORM2   = 4'd1,
    ST_NORM3   = 4'd2,
    ST_WARNHI1 = 4'd3,
    ST_WARNHI2 = 4'd4,
    ST_CRITHI  = 4'd5,
    ST_WARNLO1 = 4'd6,
    ST_WARNLO2 = 4'd7,
    ST_CRITLO  = 4'd8
  } state_t;

  state_t                   state_r;
  state_t                   state_nxt;
  tmpal_pkg::ev_t           ev_nxt;
  tmpal_pkg::led_t          led_nxt;
  logic                     res_valid_r;
  tmpal_pkg::result_t       res_r;
  logic signed [tmpal_pkg::TEMP_W-1:0] t;

  assign t         = smp.temperature;
  // Advance when the result register is free or being drained this cycle.
  assign take      = smp_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    state_nxt = state_r;
    ev_nxt    = tmpal_pkg::EV_NONE;
    led_nxt   = tmpal_pkg::LED_NONE;
    if (smp.op) begin
      state_nxt = ST_NORM1;
    end else begin
      case (state_r)
        ST_NORM1: begin
          if (t <= thr.warn_low) begin
            ev_nxt = tmpal_pkg::EV_LOWARN; led_nxt = tmpal_pkg::LED_WARN;
            state_nxt = ST_WARNLO1;
          end else if (t >= thr.warn_high) begin
            ev_nxt = tmpal_pkg::EV_HIWARN; led_nxt = tmpal_pkg::LED_WARN;
            state_nxt = ST_WARNHI1;
          end
        end
        // Came back from the low side: a repeat low warning raises no event.
        ST_NORM2: begin
          if (t >= thr.warn_high) begin
            ev_nxt = tmpal_pkg::EV_HIWARN; led_nxt = tmpal_pkg::LED_WARN;
            state_nxt = ST_WARNHI1;
          end else if (t <= thr.warn_low) begin
            led_nxt = tmpal_pkg::LED_WARN; state_nxt = ST_WARNLO1;
          end
        end
        // Came back from the high side: a repeat high warning raises no event.
        ST_NORM3: begin
          if (t <= thr.warn_low) begin
            ev_nxt = tmpal_pkg::EV_LOWARN; led_nxt = tmpal_pkg::LED_WARN;
            state_nxt = ST_WARNLO1;
          end else if (t >= thr.warn_high) begin
            led_nxt = tmpal_pkg::LED_WARN; state_nxt = ST_WARNHI1;
          end
        end
        ST_WARNHI1: begin
          if (t >= thr.crit_high) begin
            ev_nxt = tmpal_pkg::EV_HIALARM; led_nxt = tmpal_pkg::LED_CRIT;
            state_nxt = ST_CRITHI;
          end else if (t < thr.warn_high) begin
            led_nxt = tmpal_pkg::LED_NORMAL; state_nxt = ST_NORM3;
          end
        end
        ST_WARNHI2: begin
          if (t >= thr.crit_high) begin
            led_nxt = tmpal_pkg::LED_CRIT; state_nxt = ST_CRITHI;
          end else if (t < thr.warn_high) begin
            led_nxt = tmpal_pkg::LED_NORMAL; state_nxt = ST_NORM3;
          end
        end
        ST_CRITHI: begin
          if (t < thr.crit_high) begin
            led_nxt = tmpal_pkg::LED_WARN; state_nxt = ST_WARNHI2;
          end
        end
        ST_WARNLO1: begin
          if (t <= thr.crit_low) begin
            ev_nxt = tmpal_pkg::EV_LOALARM; led_nxt = tmpal_pkg::LED_CRIT;
            state_nxt = ST_CRITLO;
          end else if (t > thr.warn_low) begin
            led_nxt = tmpal_pkg::LED_NORMAL; state_nxt = ST_NORM2;
          end
        end
        ST_WARNLO2: begin
          if (t <= thr.crit_low) begin
            led_nxt = tmpal_pkg::LED_CRIT; state_nxt = ST_CRITLO;
          end else if (t > thr.warn_low) begin
            led_nxt = tmpal_pkg::LED_NORMAL; state_nxt = ST_NORM2;
          end
        end
        ST_CRITLO: begin
          if (t > thr.crit_low) begin
            led_nxt = tmpal_pkg::LED_WARN; state_nxt = ST_WARNLO2;
          end
        end
        default: begin
          led_nxt   = tmpal_pkg::LED_NORMAL;
          state_nxt = ST_NORM1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_NORM1;
      res_valid_r <= 1'b0;
    end else begin
      if (take) begin
        state_r             <= state_nxt;
        res_valid_r         <= 1'b1;
        res_r.alarm_event   <= ev_nxt;
        res_r.led_command   <= led_nxt;
        res_r.monitor_state <= state_nxt;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
